// ===== src/spq_pkg.sv =====
// Shared types and operation codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int TagWidth  = 16;
   localparam int PrioWidth = 32;
   localparam int OccWidth  = 5;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_TOP    = 2'd2;

   typedef struct packed {
      logic [1:0]                  kind;
      logic signed [PrioWidth-1:0] prio;
      logic [TagWidth-1:0]         tag;
   } req_type;

   typedef struct packed {
      logic [TagWidth-1:0] head_tag;
      logic                head_valid;
      logic                overflow;
      logic [OccWidth-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [PrioWidth-1:0] prio;
      logic [TagWidth-1:0]         tag;
   } entry_type;

   // Broadcast from the top level to every cell in the chain.
   typedef struct packed {
      logic                        ins;
      logic                        pop;
      logic signed [PrioWidth-1:0] prio;
      logic [TagWidth-1:0]         tag;
   } ctrl_type;

endpackage

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  ctrl_type  ctrl,
   input  logic      occupied,
   input  logic      prev_lower,
   input  entry_type prev_entry,
   input  entry_type next_entry,
   output logic      lower,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // Strictly lower priority, or empty: the new entry belongs at or before this slot.
   assign lower = !occupied || ($signed(entry_ff.prio) < $signed(ctrl.prio));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (lower && !prev_lower) begin
            entry_in.prio = ctrl.prio;
            entry_in.tag  = ctrl.tag;
         end else if (lower) begin
            entry_in = prev_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// Sorted priority queue built as a chain of shifting cells.
// Result: registered, valid in the cycle after the transaction is accepted.
// Throughput: one insert, pop or top transaction per cycle while no result is held by rsp_stall; every cell
// decides locally from the broadcast and its neighbors, so no search loop.
// Reset: synchronous, active high; clears the entry count and the result valid.
// Cell contents are not cleared; slots at or above the count never reach the result.
`timescale 1ns / 1ps

module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic      accept;
   logic      full;
   logic      is_insert;
   logic      is_pop;
   ctrl_type  ctrl;
   logic [31:0] count_ext;

   logic      lower     [DEPTH];
   entry_type cell_data [DEPTH];

   // Hold the request whenever a finished result still waits downstream.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full      = (count_ff == CountWidth'(DEPTH));
   assign is_insert = (req_data.kind == KIND_INSERT);
   assign is_pop    = (req_data.kind == KIND_POP);

   // Broadcast the operation; drop inserts into a full queue and pops from an empty one.
   always_comb begin
      ctrl.ins  = accept && is_insert && !full;
      ctrl.pop  = accept && is_pop && (count_ff != '0);
      ctrl.prio = req_data.prio;
      ctrl.tag  = req_data.tag;
   end

   // Cell chain: each cell sees its left neighbor for inserts and its right for pops.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      prev_lower_w;
      entry_type prev_entry_w;
      entry_type next_entry_w;

      if (i == 0) begin : g_first
         assign prev_lower_w = 1'b0;
         assign prev_entry_w = '0;
      end else begin : g_mid
         assign prev_lower_w = lower[i-1];
         assign prev_entry_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry_w = '0;
      end else begin : g_body
         assign next_entry_w = cell_data[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CountWidth'(i) < count_ff),
         .prev_lower (prev_lower_w),
         .prev_entry (prev_entry_w),
         .next_entry (next_entry_w),
         .lower      (lower[i]),
         .entry      (cell_data[i])
      );
   end

   // Advance the count with the chain.
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CountWidth'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   assign count_ext = 32'(count_in);

   // Build the result from the head as it stands after this transaction.
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_data_in.head_valid = (count_in != '0);
      rsp_data_in.overflow   = accept && is_insert && full;
      rsp_data_in.occupancy  = count_ext[OccWidth-1:0];
      if (count_in == '0) begin
         rsp_data_in.head_tag = '0;
      end else if (ctrl.ins && lower[0]) begin
         rsp_data_in.head_tag = req_data.tag;
      end else if (ctrl.pop) begin
         rsp_data_in.head_tag = cell_data[1].tag;
      end else begin
         rsp_data_in.head_tag = cell_data[0].tag;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
